@@ src/pcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and constants for the pixel to character cell packer.
// ----------------------------------------------------------------------------
package pcp_pkg;

    localparam int PIXW       = 8;   // pixel and packed byte width
    localparam int CELLW      = 12;  // cell index width
    localparam int CROWW      = 5;   // cell row width
    localparam int CFG_IDXW   = 3;   // register index width
    localparam int CFG_DATAW  = 10;  // widest register

    localparam int MODEW      = 2;
    localparam int IMG_WW     = 10;  // image_width register
    localparam int IMG_HW     = 9;   // image_height register

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int SPRITE_WIDTH = 24;
    localparam int SPRITE_ROWS  = 21;

    localparam int HIRES_GROUP = 8;
    localparam int MULTI_GROUP = 4;
    localparam int CELL_LINES  = 8;

    localparam logic [MODEW-1:0] MODE_HIRES  = 2'd0;
    localparam logic [MODEW-1:0] MODE_MULTI  = 2'd1;
    localparam logic [MODEW-1:0] MODE_SPRITE = 2'd2;

    localparam logic [IMG_WW-1:0] RST_IMAGE_WIDTH  = 10'd8;
    localparam logic [IMG_HW-1:0] RST_IMAGE_HEIGHT = 9'd8;

    typedef enum logic [CFG_IDXW-1:0] {
        REG_PACK_MODE        = 3'd0,
        REG_IMAGE_WIDTH      = 3'd1,
        REG_IMAGE_HEIGHT     = 3'd2,
        REG_BACKGROUND_ONE   = 3'd3,
        REG_BACKGROUND_TWO   = 3'd4,
        REG_BACKGROUND_THREE = 3'd5
    } t_cfg_reg;

    // multicolor 2-bit codes
    localparam logic [1:0] CODE_BG1   = 2'b00;
    localparam logic [1:0] CODE_BG2   = 2'b10;
    localparam logic [1:0] CODE_BG3   = 2'b01;
    localparam logic [1:0] CODE_OTHER = 2'b11;

    typedef struct packed {
        logic             multi;
        logic [PIXW-1:0]  bg_one;
        logic [PIXW-1:0]  bg_two;
        logic [PIXW-1:0]  bg_three;
    } t_merge_cfg;

endpackage

@@ src/pcp_pixel_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pixel_if
// Pixel request channel: one raw pixel per request.
// ----------------------------------------------------------------------------
interface pcp_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [pcp_pkg::PIXW-1:0]  pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

@@ src/pcp_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_byte_if
// Packed byte request channel with cell position and image end flag.
// ----------------------------------------------------------------------------
interface pcp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [pcp_pkg::PIXW-1:0]   packed_byte;
    logic [pcp_pkg::CELLW-1:0]  cell_index;
    logic [pcp_pkg::CROWW-1:0]  cell_row;
    logic                       last_of_image;

    modport source (output valid, output packed_byte, output cell_index,
                    output cell_row, output last_of_image, input ready);
    modport sink   (input valid, input packed_byte, input cell_index,
                    input cell_row, input last_of_image, output ready);
endinterface

@@ src/pcp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pcp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pcp_pkg::CFG_IDXW-1:0]   reg_index;
    logic [pcp_pkg::CFG_DATAW-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ src/pcp_bit_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_bit_merge
// Encodes one pixel (hires bit or multicolor code) and ORs it into the
// byte under construction at the given slot.
// ----------------------------------------------------------------------------
module pcp_bit_merge (
    input  logic [pcp_pkg::PIXW-1:0] i_pixel,
    input  logic [2:0]               i_slot,
    input  pcp_pkg::t_merge_cfg      i_cfg,
    input  logic [pcp_pkg::PIXW-1:0] i_acc,
    output logic [pcp_pkg::PIXW-1:0] o_acc
);
    import pcp_pkg::*;

    logic [1:0]      code;
    logic [PIXW-1:0] multi_bits;
    logic [PIXW-1:0] hires_bits;

    always_comb begin
        if (i_pixel == i_cfg.bg_one) begin
            code = CODE_BG1;
        end else if (i_pixel == i_cfg.bg_two) begin
            code = CODE_BG2;
        end else if (i_pixel == i_cfg.bg_three) begin
            code = CODE_BG3;
        end else begin
            code = CODE_OTHER;
        end
    end

    // slot s of 4 sits at bit 6 - 2s, i.e. 2 * (3 - s)
    assign multi_bits = PIXW'(code) << {~i_slot[1:0], 1'b0};
    assign hires_bits = (i_pixel != '0) ? (PIXW'(8'h80) >> i_slot) : '0;

    assign o_acc = i_acc | (i_cfg.multi ? multi_bits : hires_bits);

endmodule

@@ src/pixel_to_char_cell_packer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_char_cell_packer_unit
// Packs raster-ordered pixels into hires, multicolor or sprite bitmap bytes.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle when not stalled and returns a packed byte every
// 8 pixels (hires, sprite) or every 4 (multicolor), and a zero-padded byte
// wherever a row ends part way through a group. A pixel is held in the input
// register; encode, counter update and cell index add then land the byte in
// the output register. Unstalled, the sustained rate is one pixel per clock,
// set by that single state-update stage. Output backpressure stalls the input
// through the ready chain. Registers are taken on the config channel at any
// time but may only be changed while no pixel is in flight; writing the mode,
// width or height restarts the image at its first pixel.
// ----------------------------------------------------------------------------
module pixel_to_char_cell_packer_unit #(
    parameter int MAX_WIDTH  = pcp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pcp_pkg::DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pcp_cfg_if.sink           i_cfg,
    pcp_pixel_if.sink         i_pix,
    pcp_byte_if.source        o_byte
);
    import pcp_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);        // column counter
    localparam int WW   = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int RW   = $clog2(MAX_HEIGHT);       // row counter
    localparam int HW   = $clog2(MAX_HEIGHT + 1);   // effective height
    localparam int CMPW = (WW > IMG_WW) ? WW : IMG_WW;
    localparam int CMPH = (HW > IMG_HW) ? HW : IMG_HW;

    // configuration
    logic [MODEW-1:0]  r_mode;
    logic [IMG_WW-1:0] r_image_width;
    logic [IMG_HW-1:0] r_image_height;
    logic [PIXW-1:0]   r_bg_one, r_bg_two, r_bg_three;

    // input stage
    logic              r_in_valid;
    logic [PIXW-1:0]   r_in_pixel;

    // packing state
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [PIXW-1:0]   r_acc, n_acc;
    logic [CELLW-1:0]  r_base, n_base;

    // output stage
    logic              r_out_valid;
    logic [PIXW-1:0]   r_out_byte;
    logic [CELLW-1:0]  r_out_index;
    logic [CROWW-1:0]  r_out_row;
    logic              r_out_last;

    logic              cfg_wr;
    logic              restart;
    logic              process;
    logic              multi, sprite;
    logic [WW-1:0]     width_eff;
    logic [HW-1:0]     height_eff;
    logic [CMPW-1:0]   w_raw;
    logic [CMPH-1:0]   h_raw;
    logic [2:0]        slot;
    logic              group_full;
    logic              row_end, image_end, emit;
    logic [PIXW-1:0]   merged;
    logic [CELLW-1:0]  idx;
    logic [CROWW-1:0]  crow;
    logic [WW:0]       cells_per_row;
    t_merge_cfg        merge_cfg;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    assign restart = cfg_wr && (i_cfg.reg_index == REG_PACK_MODE ||
                                i_cfg.reg_index == REG_IMAGE_WIDTH ||
                                i_cfg.reg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_HIRES;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_bg_one       <= '0;
            r_bg_two       <= '0;
            r_bg_three     <= '0;
        end else if (cfg_wr) begin
            case (t_cfg_reg'(i_cfg.reg_index))
                REG_PACK_MODE:        r_mode         <= i_cfg.wr_data[MODEW-1:0];
                REG_IMAGE_WIDTH:      r_image_width  <= i_cfg.wr_data[IMG_WW-1:0];
                REG_IMAGE_HEIGHT:     r_image_height <= i_cfg.wr_data[IMG_HW-1:0];
                REG_BACKGROUND_ONE:   r_bg_one       <= i_cfg.wr_data[PIXW-1:0];
                REG_BACKGROUND_TWO:   r_bg_two       <= i_cfg.wr_data[PIXW-1:0];
                REG_BACKGROUND_THREE: r_bg_three     <= i_cfg.wr_data[PIXW-1:0];
                default: ;
            endcase
        end
    end

    // ---- geometry ----
    assign multi  = (r_mode == MODE_MULTI);
    assign sprite = (r_mode == MODE_SPRITE);
    assign w_raw  = CMPW'(r_image_width);
    assign h_raw  = CMPH'(r_image_height);

    always_comb begin
        if (sprite) begin
            width_eff  = WW'(SPRITE_WIDTH);
            height_eff = HW'(SPRITE_ROWS);
        end else begin
            if (r_image_width == '0) begin
                width_eff = WW'(1);
            end else if (w_raw > CMPW'(MAX_WIDTH)) begin
                width_eff = WW'(MAX_WIDTH);
            end else begin
                width_eff = WW'(w_raw);
            end
            if (r_image_height == '0) begin
                height_eff = HW'(1);
            end else if (h_raw > CMPH'(MAX_HEIGHT)) begin
                height_eff = HW'(MAX_HEIGHT);
            end else begin
                height_eff = HW'(h_raw);
            end
        end
    end

    // ---- handshake ----
    assign process     = r_in_valid && (!r_out_valid || o_byte.ready);
    assign i_pix.ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_in_pixel <= i_pix.pixel_value;
        end
    end

    // ---- packing ----
    assign slot       = multi ? {1'b0, r_col[1:0]} : r_col[2:0];
    assign group_full = multi ? (r_col[1:0] == 2'b11) : (r_col[2:0] == 3'b111);
    assign row_end    = (WW'(r_col) + WW'(1)) >= width_eff;
    assign image_end  = row_end && ((HW'(r_row) + HW'(1)) >= height_eff);
    assign emit       = group_full || row_end;

    assign merge_cfg.multi    = multi;
    assign merge_cfg.bg_one   = r_bg_one;
    assign merge_cfg.bg_two   = r_bg_two;
    assign merge_cfg.bg_three = r_bg_three;

    pcp_bit_merge u_merge (
        .i_pixel (r_in_pixel),
        .i_slot  (slot),
        .i_cfg   (merge_cfg),
        .i_acc   (r_acc),
        .o_acc   (merged)
    );

    always_comb begin
        if (sprite) begin
            idx  = CELLW'(r_col >> 3);
            crow = CROWW'(r_row);
        end else begin
            idx  = r_base + CELLW'(multi ? (r_col >> 2) : (r_col >> 3));
            crow = CROWW'(r_row[2:0]);
        end
    end

    // ceil(width / group)
    assign cells_per_row = multi ? ((WW+1)'(width_eff) + (WW+1)'(MULTI_GROUP - 1)) >> 2
                                 : ((WW+1)'(width_eff) + (WW+1)'(HIRES_GROUP - 1)) >> 3;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_acc  = r_acc;
        n_base = r_base;
        if (restart) begin
            n_col  = '0;
            n_row  = '0;
            n_acc  = '0;
            n_base = '0;
        end else if (process) begin
            n_acc = emit ? '0 : merged;
            if (image_end) begin
                n_col  = '0;
                n_row  = '0;
                n_base = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + RW'(1);
                // new cell row starts every eight pixel rows
                if (!sprite && (n_row[2:0] == 3'd0)) begin
                    n_base = r_base + CELLW'(cells_per_row);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_acc  <= '0;
            r_base <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_acc  <= n_acc;
            r_base <= n_base;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && emit) begin
            r_out_byte  <= merged;
            r_out_index <= idx;
            r_out_row   <= crow;
            r_out_last  <= image_end;
        end
    end

    assign o_byte.valid         = r_out_valid;
    assign o_byte.packed_byte   = r_out_byte;
    assign o_byte.cell_index    = r_out_index;
    assign o_byte.cell_row      = r_out_row;
    assign o_byte.last_of_image = r_out_last;

endmodule
